### rtl/validated_moving_average_3ch_defines.svh
// assertion macros shared by the validated moving average block
`ifndef VALIDATED_MOVING_AVERAGE_3CH_DEFINES_SVH
`define VALIDATED_MOVING_AVERAGE_3CH_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define VMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define VMA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `VMA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define VMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/vma_pkg.sv
// types and constants of the validated moving average block
`default_nettype none

package vma_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 16;

  // quotient bits of the shared divider, enough for the widest mean
  localparam int unsigned QUO_W = 17;

  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned HUM_W   = 14;
  localparam int unsigned PRESS_W = 17;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ERR_W   = 8;
  localparam int unsigned WS_W    = 5;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MAX = 3'd6;

  localparam logic [WS_W-1:0]           WINDOW_RST    = 5'd8;
  localparam logic signed [TEMP_W-1:0]  TEMP_MIN_RST  = -15'sd4000;
  localparam logic signed [TEMP_W-1:0]  TEMP_MAX_RST  = 15'sd8500;
  localparam logic [HUM_W-1:0]          HUM_MIN_RST   = 14'd0;
  localparam logic [HUM_W-1:0]          HUM_MAX_RST   = 14'd10000;
  localparam logic [PRESS_W-1:0]        PRESS_MIN_RST = 17'd30000;
  localparam logic [PRESS_W-1:0]        PRESS_MAX_RST = 17'd110000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRESS_W-1:0]       press;
    logic [HUM_W-1:0]         hum;
    logic signed [TEMP_W-1:0] temp;
  } win_entry_t;

endpackage

`default_nettype wire

### rtl/vma_window.sv
// sample window memory with per-entry valid bits and registered read
`default_nettype none

module vma_window #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire vma_pkg::win_entry_t wdata_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output      vma_pkg::win_entry_t rdata_o
);
  import vma_pkg::*;

  logic [Depth-1:0] vld_q;
  win_entry_t       mem_q [Depth];
  win_entry_t       rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

### rtl/vma_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module vma_div #(
  parameter int unsigned DivdW = 23,
  parameter int unsigned DivsW = 5
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [DivdW-1:0]           dividend_i,
  input  wire logic [DivsW-1:0]           divisor_i,
  output      logic                       done_o,
  output      logic [vma_pkg::QUO_W-1:0]  quotient_o
);
  import vma_pkg::*;

  localparam int unsigned RemW = DivdW - QUO_W;
  localparam int unsigned CntW = $clog2(QUO_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [RemW-1:0]   rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [DivsW-1:0]  dvs_q;
  logic [RemW:0]     trial;
  logic [RemW:0]     dvs_ext;
  logic              fits;

  // the upper dividend bits start below the divisor, so the quotient fits QUO_W
  assign trial   = {rem_q, quo_q[QUO_W-1]};
  assign dvs_ext = (RemW + 1)'(dvs_q);
  assign fits    = trial >= dvs_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DivdW-1:QUO_W];
      quo_q <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? RemW'(trial - dvs_ext) : RemW'(trial);
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/validated_moving_average_3ch.sv
// top level of the range-checked three-channel moving average filter
`default_nettype none

`include "validated_moving_average_3ch_defines.svh"

// Each accepted reading is range checked against the min/max registers. A
// failed or rejected reading goes straight to the output state, returns an
// invalid result through the output register and bumps the saturating error
// run. A good reading is written into the three windows at the shared head,
// the filled entries are summed at one entry per cycle out of the window
// memory, and the three rounded means come out of one shared divider, one
// channel after the other. Before the write, a head left beyond a shrunk
// window is wrapped back one window length at a time. The input is ready
// only while the block is idle; a finished result waits in the output
// register, so the next reading can start while it is still pending.
module validated_moving_average_3ch #(
  parameter int unsigned MAX_WINDOW = vma_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [vma_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [vma_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input readings
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // temp_sample, hum_sample, press_sample, sample_time, zero pad
  input  wire logic [vma_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // read_failed
  input  wire logic [vma_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // filtered results
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // temp_mean, hum_mean, press_mean, mean_time, error_run, zero pad
  output      logic [vma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // result_valid, status
  output      logic [vma_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import vma_pkg::*;

  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AccW = QUO_W + 1 + CntW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WRAP = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    CH_TEMP  = 2'd0,
    CH_HUM   = 2'd1,
    CH_PRESS = 2'd2
  } chan_e;

  // configuration registers
  logic [WS_W-1:0]           ws_q;
  logic signed [TEMP_W-1:0]  tmin_q, tmax_q;
  logic [HUM_W-1:0]          hmin_q, hmax_q;
  logic [PRESS_W-1:0]        pmin_q, pmax_q;

  // control state
  state_e           state_q, state_d;
  chan_e            ch_q, ch_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             rdv_q, rdv_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic             div_start_q, div_start_d;
  logic             out_valid_q, out_valid_d;

  // working payload
  win_entry_t               smp_q;
  logic [TIME_W-1:0]        time_q;
  logic                     rv_q;
  status_e                  status_q;
  logic signed [AccW-1:0]   tacc_q, hacc_q, pacc_q;
  logic [TEMP_W-1:0]        tmean_q;
  logic [HUM_W-1:0]         hmean_q;
  logic [PRESS_W-1:0]       pmean_q;

  // output register
  logic                     o_rv_q;
  status_e                  o_status_q;
  logic [TEMP_W-1:0]        o_tmean_q;
  logic [HUM_W-1:0]         o_hmean_q;
  logic [PRESS_W-1:0]       o_pmean_q;
  logic [TIME_W-1:0]        o_time_q;
  logic [ERR_W-1:0]         o_err_q;

  logic                     in_acc;
  logic                     in_failed;
  logic signed [TEMP_W-1:0] in_temp;
  logic [HUM_W-1:0]         in_hum;
  logic [PRESS_W-1:0]       in_press;
  logic                     in_range;
  logic                     item_bad;
  logic [CntW-1:0]          win;
  logic [CntW-1:0]          head_ext;
  logic                     wrap_need;
  logic                     win_we;
  logic                     out_load;
  win_entry_t               rd_entry;
  logic signed [AccW-1:0]   sel_acc;
  logic [AccW-1:0]          sel_mag;
  logic [AccW-1:0]          dividend;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic [QUO_W-1:0]         mean_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= WINDOW_RST;
      tmin_q <= TEMP_MIN_RST;
      tmax_q <= TEMP_MAX_RST;
      hmin_q <= HUM_MIN_RST;
      hmax_q <= HUM_MAX_RST;
      pmin_q <= PRESS_MIN_RST;
      pmax_q <= PRESS_MAX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW:    ws_q   <= cfg_data_i[WS_W-1:0];
        CFG_TEMP_MIN:  tmin_q <= $signed(cfg_data_i[TEMP_W-1:0]);
        CFG_TEMP_MAX:  tmax_q <= $signed(cfg_data_i[TEMP_W-1:0]);
        CFG_HUM_MIN:   hmin_q <= cfg_data_i[HUM_W-1:0];
        CFG_HUM_MAX:   hmax_q <= cfg_data_i[HUM_W-1:0];
        CFG_PRESS_MIN: pmin_q <= cfg_data_i[PRESS_W-1:0];
        CFG_PRESS_MAX: pmax_q <= cfg_data_i[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_failed     = s_axis_tuser[0];
  assign in_temp       = $signed(s_axis_tdata[14:0]);
  assign in_hum        = s_axis_tdata[28:15];
  assign in_press      = s_axis_tdata[45:29];

  assign in_range = (in_temp >= tmin_q) && (in_temp <= tmax_q) &&
                    (in_hum >= hmin_q) && (in_hum <= hmax_q) &&
                    (in_press >= pmin_q) && (in_press <= pmax_q);
  assign item_bad = in_failed || !in_range;

  // effective window: clamp to the depth, zero acts as one
  always_comb begin
    if (32'(ws_q) > 32'(MAX_WINDOW)) begin
      win = CntW'(MAX_WINDOW);
    end else if (ws_q == '0) begin
      win = CntW'(1);
    end else begin
      win = CntW'(ws_q);
    end
  end

  assign head_ext  = CntW'(head_q);
  assign wrap_need = head_ext >= win;
  assign win_we    = (state_q == S_WRAP) && !wrap_need;
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    head_d      = head_q;
    fill_d      = fill_q;
    iss_d       = iss_q;
    rdv_d       = 1'b0;
    err_d       = err_q;
    div_start_d = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (item_bad) begin
            err_d   = (err_q == '1) ? err_q : err_q + 1'b1;
            state_d = S_OUT;
          end else begin
            err_d   = '0;
            state_d = S_WRAP;
          end
        end
      end
      S_WRAP: begin
        // head left beyond a shrunk window is brought back one window per cycle
        if (wrap_need) begin
          head_d = IdxW'(head_ext - win);
        end else begin
          head_d  = (CntW'(head_ext + 1'b1) == win) ? '0 : IdxW'(head_q + 1'b1);
          fill_d  = (fill_q < win) ? CntW'(fill_q + 1'b1) : win;
          iss_d   = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (iss_q < fill_q) begin
          iss_d = CntW'(iss_q + 1'b1);
          rdv_d = 1'b1;
        end else if (!rdv_q) begin
          ch_d        = CH_TEMP;
          div_start_d = 1'b1;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ch_q == CH_PRESS) begin
            state_d = S_OUT;
          end else begin
            ch_d        = (ch_q == CH_TEMP) ? CH_HUM : CH_PRESS;
            div_start_d = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_TEMP;
      head_q      <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      rdv_q       <= 1'b0;
      err_q       <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      rdv_q       <= rdv_d;
      err_q       <= err_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  vma_window #(
    .Depth (MAX_WINDOW),
    .AddrW (IdxW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (win_we),
    .waddr_i (head_q),
    .wdata_i (smp_q),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  always_comb begin
    case (ch_q)
      CH_TEMP:  sel_acc = tacc_q;
      CH_HUM:   sel_acc = hacc_q;
      default:  sel_acc = pacc_q;
    endcase
  end

  // round half away from zero on the magnitude
  assign sel_mag  = sel_acc[AccW-1] ? AccW'(-sel_acc) : AccW'(sel_acc);
  assign dividend = AccW'(sel_mag + AccW'(fill_q >> 1));

  vma_div #(
    .DivdW (AccW),
    .DivsW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dividend),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign mean_res = sel_acc[AccW-1] ? QUO_W'(~div_quo + 1'b1) : div_quo;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q.temp  <= in_temp;
      smp_q.hum   <= in_hum;
      smp_q.press <= in_press;
      rv_q        <= !item_bad;
      status_q    <= in_failed ? ST_FAIL : (item_bad ? ST_RANGE : ST_OK);
      time_q      <= item_bad ? '0 : s_axis_tdata[77:46];
      tmean_q     <= '0;
      hmean_q     <= '0;
      pmean_q     <= '0;
    end
    if (win_we) begin
      tacc_q <= '0;
      hacc_q <= '0;
      pacc_q <= '0;
    end else if (rdv_q) begin
      tacc_q <= tacc_q + {{(AccW - TEMP_W){rd_entry.temp[TEMP_W-1]}}, rd_entry.temp};
      hacc_q <= hacc_q + {{(AccW - HUM_W){1'b0}}, rd_entry.hum};
      pacc_q <= pacc_q + {{(AccW - PRESS_W){1'b0}}, rd_entry.press};
    end
    if (div_done) begin
      case (ch_q)
        CH_TEMP:  tmean_q <= mean_res[TEMP_W-1:0];
        CH_HUM:   hmean_q <= mean_res[HUM_W-1:0];
        default:  pmean_q <= mean_res[PRESS_W-1:0];
      endcase
    end
    if (out_load) begin
      o_rv_q     <= rv_q;
      o_status_q <= status_q;
      o_tmean_q  <= tmean_q;
      o_hmean_q  <= hmean_q;
      o_pmean_q  <= pmean_q;
      o_time_q   <= time_q;
      o_err_q    <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, o_err_q, o_time_q, o_pmean_q, o_hmean_q, o_tmean_q};
  assign m_axis_tuser  = {o_status_q, o_rv_q};

  `VMA_ASSERT(a_sum_nonempty, clk_i, rst_ni, (state_q == S_SUM) |-> (fill_q != '0),
              "averaging started with an empty window")
  `VMA_ASSERT_NEVER(a_done_in_div, clk_i, rst_ni, div_done && (state_q != S_DIV),
                    "divider finished outside the divide phase")
  `VMA_ASSERT(a_bad_result, clk_i, rst_ni,
              (out_valid_q && !o_rv_q) |-> (o_err_q != '0 && o_time_q == '0 && o_status_q != ST_OK),
              "invalid result without error run or with data")
  `VMA_ASSERT(a_good_result, clk_i, rst_ni,
              (out_valid_q && o_rv_q) |-> (o_err_q == '0 && o_status_q == ST_OK),
              "valid result with nonzero error run or status")

endmodule

`default_nettype wire

### tb/validated_moving_average_3ch_test.sv
// self-checking test of the range-checked three-channel moving average filter
module validated_moving_average_3ch_test;
  import vma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 120;

  typedef struct {
    logic        ok;
    status_e     st;
    logic [14:0] temp;
    logic [13:0] hum;
    logic [16:0] press;
    logic [31:0] stamp;
    logic [7:0]  run;
  } mean_result_t;

  class moving_mean_board;
    mean_result_t expected_means[$];
    int temp_hist[MAX_WINDOW_DEF];
    int hum_hist[MAX_WINDOW_DEF];
    int press_hist[MAX_WINDOW_DEF];
    int unsigned head, fill, err_run;
    int unsigned win_reg;
    int t_lo, t_hi, h_lo, h_hi, p_lo, p_hi;
    int unsigned errors, n_seen, n_ok, n_fail, n_range, top_run, top_fill;

    function new();
      win_reg = WINDOW_RST;
      t_lo = TEMP_MIN_RST;
      t_hi = TEMP_MAX_RST;
      h_lo = HUM_MIN_RST;
      h_hi = HUM_MAX_RST;
      p_lo = PRESS_MIN_RST;
      p_hi = PRESS_MAX_RST;
      head = 0;
      fill = 0;
      err_run = 0;
      foreach (temp_hist[i]) begin
        temp_hist[i] = 0;
        hum_hist[i] = 0;
        press_hist[i] = 0;
      end
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      logic signed [TEMP_W-1:0] sv;
      sv = v[TEMP_W-1:0];
      case (idx)
        CFG_WINDOW: win_reg = v[WS_W-1:0];
        CFG_TEMP_MIN: t_lo = sv;
        CFG_TEMP_MAX: t_hi = sv;
        CFG_HUM_MIN: h_lo = v[HUM_W-1:0];
        CFG_HUM_MAX: h_hi = v[HUM_W-1:0];
        CFG_PRESS_MIN: p_lo = v[PRESS_W-1:0];
        CFG_PRESS_MAX: p_hi = v[PRESS_W-1:0];
        default: ;
      endcase
    endfunction

    // halves go away from zero
    function longint round_mean(longint sum, longint n);
      if (sum >= 0) return (sum + n / 2) / n;
      return -((-sum + n / 2) / n);
    endfunction

    function void note_reading(bit failed, logic signed [TEMP_W-1:0] t,
                               logic [HUM_W-1:0] h, logic [PRESS_W-1:0] p,
                               logic [TIME_W-1:0] ts);
      mean_result_t r;
      int tv;
      int hv, pv;
      int unsigned w, slot;
      longint st, sh, sp;
      bit in_range;
      tv = t;
      hv = h;
      pv = p;
      in_range = tv >= t_lo && tv <= t_hi && hv >= h_lo && hv <= h_hi &&
                 pv >= p_lo && pv <= p_hi;
      n_seen++;
      if (failed || !in_range) begin
        if (err_run < 255) err_run++;
        if (err_run > top_run) top_run = err_run;
        if (failed) n_fail++;
        else n_range++;
        r.ok = 1'b0;
        r.st = failed ? ST_FAIL : ST_RANGE;
        r.temp = '0;
        r.hum = '0;
        r.press = '0;
        r.stamp = '0;
        r.run = 8'(err_run);
      end else begin
        err_run = 0;
        n_ok++;
        w = win_reg;
        if (w > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
        if (w == 0) w = 1;
        // a shrunk window pulls the head back inside it
        slot = head % w;
        temp_hist[slot] = tv;
        hum_hist[slot] = hv;
        press_hist[slot] = pv;
        head = (slot + 1) % w;
        if (fill < w) fill++;
        if (fill > w) fill = w;
        if (fill > top_fill) top_fill = fill;
        st = 0;
        sh = 0;
        sp = 0;
        for (int i = 0; i < fill; i++) begin
          st += temp_hist[i];
          sh += hum_hist[i];
          sp += press_hist[i];
        end
        r.ok = 1'b1;
        r.st = ST_OK;
        r.temp = 15'(round_mean(st, fill));
        r.hum = 14'(round_mean(sh, fill));
        r.press = 17'(round_mean(sp, fill));
        r.stamp = ts;
        r.run = '0;
      end
      expected_means.push_back(r);
    endfunction

    function void field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h (item %0d of %0d)", name, got, want,
                         n_seen - expected_means.size(), n_seen));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
      mean_result_t e;
      if (expected_means.size() == 0) begin
        report("result item with no reading pending");
        return;
      end
      e = expected_means.pop_front();
      field("result_valid", u[0], e.ok);
      field("status", u[2:1], e.st);
      field("temp_mean", d[14:0], e.temp);
      field("hum_mean", d[28:15], e.hum);
      field("press_mean", d[45:29], e.press);
      field("mean_time", d[77:46], e.stamp);
      field("error_run", d[85:78], e.run);
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // temp_sample, hum_sample, press_sample, sample_time, zero pad
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  // read_failed
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // temp_mean, hum_mean, press_mean, mean_time, error_run, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // result_valid, status
  logic [OUT_USER_W-1:0] m_axis_tuser;

  moving_mean_board sb = new();
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  validated_moving_average_3ch u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 5);
  endfunction

  // mostly inside the configured range, with the bounds themselves and raw noise
  function automatic int pick_value(int lo, int hi, int unsigned w, bit sgn);
    int unsigned r;
    int unsigned raw;
    r = $urandom_range(0, 99);
    raw = $urandom & ((32'd1 << w) - 1);
    if (lo <= hi) begin
      if (r < 4) return lo;
      if (r < 8) return hi;
      if (r < 94) return lo + int'($urandom_range(0, hi - lo));
    end
    if (sgn && raw[w-1]) return int'(raw) - (1 << w);
    return int'(raw);
  endfunction

  // valid stays high into the next item when no gap is drawn
  task automatic send_reading(bit failed, logic [TEMP_W-1:0] t, logic [HUM_W-1:0] h,
                              logic [PRESS_W-1:0] p, logic [TIME_W-1:0] ts);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {2'b00, ts, p, h, t};
    s_axis_tuser <= failed;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_reading(failed, t, h, p, ts);
  endtask

  task automatic send_random(int unsigned fail_pct);
    send_reading($urandom_range(0, 99) < fail_pct,
                 TEMP_W'(pick_value(sb.t_lo, sb.t_hi, TEMP_W, 1'b1)),
                 HUM_W'(pick_value(sb.h_lo, sb.h_hi, HUM_W, 1'b0)),
                 PRESS_W'(pick_value(sb.p_lo, sb.p_hi, PRESS_W, 1'b0)),
                 $urandom);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_filter(logic [WS_W-1:0] win, logic [TEMP_W-1:0] tlo,
                                logic [TEMP_W-1:0] thi, logic [HUM_W-1:0] hlo,
                                logic [HUM_W-1:0] hhi, logic [PRESS_W-1:0] plo,
                                logic [PRESS_W-1:0] phi);
    wait_idle();
    write_register(CFG_WINDOW, win);
    write_register(CFG_TEMP_MIN, tlo);
    write_register(CFG_TEMP_MAX, thi);
    write_register(CFG_HUM_MIN, hlo);
    write_register(CFG_HUM_MAX, hhi);
    write_register(CFG_PRESS_MIN, plo);
    write_register(CFG_PRESS_MAX, phi);
  endtask

  // result side: random stalls, ready held across items when none is drawn
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int a, b;
    int unsigned n_items;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: bounds, failures, failure over range, wrap of the window
    send_reading(0, 2500, 5000, 100000, 0);
    send_reading(0, -4000, 0, 30000, 32'hFFFF_FFFF);
    send_reading(0, 8500, 10000, 110000, 32'h8000_0000);
    send_reading(0, -1, 1, 30001, 1);
    send_reading(1, 2000, 4000, 90000, 5);
    send_reading(1, 15'h3FFF, 14'h3FFF, 17'h1FFFF, 6);
    send_reading(0, -4001, 5000, 90000, 7);
    send_reading(0, 8501, 5000, 90000, 8);
    send_reading(0, 2000, 10001, 90000, 9);
    send_reading(0, 2000, 5000, 29999, 10);
    send_reading(0, 2000, 5000, 110001, 11);
    send_reading(0, 15'h4000, 0, 0, 12);
    send_reading(0, 15'h3FFF, 14'h3FFF, 17'h1FFFF, 13);
    send_reading(0, -3999, 3, 30003, 14);
    send_reading(0, -4000, 9999, 109999, 15);
    send_reading(0, -4000, 10000, 110000, 16);
    send_reading(0, -3, 2, 30000, 17);
    send_reading(0, 8500, 10000, 110000, 18);
    send_reading(0, -2, 7, 45000, 19);
    send_reading(0, 0, 0, 30000, 20);

    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 3 == 1);
      case (ph)
        0: begin
          // whole field width accepted, window of one
          program_filter(1, 15'h4000, 15'h3FFF, 0, 14'h3FFF, 0, 17'h1FFFF);
          n_items = 60;
        end
        1: begin
          program_filter(16, -4000, 8500, 0, 10000, 30000, 110000);
          n_items = 70;
        end
        2: begin
          program_filter(0, -4000, 8500, 0, 10000, 30000, 110000);
          n_items = 40;
        end
        3: begin
          program_filter(31, -4000, 8500, 0, 10000, 30000, 110000);
          n_items = 70;
        end
        4: begin
          // window shrunk with the head and fill left beyond it
          program_filter(5, -4000, 8500, 0, 10000, 30000, 110000);
          n_items = 60;
        end
        5: begin
          // empty ranges on all three channels reject everything, long enough to saturate
          program_filter(3, 8500, -4000, 10000, 0, 110000, 30000);
          n_items = 262;
        end
        default: begin
          a = $urandom_range(0, 31);
          program_filter(WS_W'(a), 0, 0, 0, 0, 0, 0);
          a = -4000 + int'($urandom_range(0, 12500));
          b = -4000 + int'($urandom_range(0, 12500));
          write_register(CFG_TEMP_MIN, CFG_DATA_W'(a < b ? a : b));
          write_register(CFG_TEMP_MAX, CFG_DATA_W'(a < b ? b : a));
          a = $urandom_range(0, 10000);
          b = $urandom_range(0, 10000);
          write_register(CFG_HUM_MIN, CFG_DATA_W'(a < b ? a : b));
          write_register(CFG_HUM_MAX, CFG_DATA_W'(a < b ? b : a));
          a = $urandom_range(30000, 110000);
          b = $urandom_range(30000, 110000);
          write_register(CFG_PRESS_MIN, CFG_DATA_W'(a < b ? a : b));
          write_register(CFG_PRESS_MAX, CFG_DATA_W'(a < b ? b : a));
          n_items = 65;
        end
      endcase
      for (int i = 0; i < n_items; i++) send_random(ph == 5 ? 20 : 4);
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d readings: %0d averaged, %0d driver failures, %0d out of range",
             sb.n_seen, sb.n_ok, sb.n_fail, sb.n_range);
    $display("windows 0 to 31 incl. shrink, widest fill %0d, longest error run %0d",
             sb.top_fill, sb.top_run);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
